[hdl/ppke_pkg.sv]
package ppke_pkg;

  localparam int NUM_BUTTONS = 12;
  localparam int COUNT_WIDTH = 16;

  localparam int BTN_FIELD = 12;
  localparam int TICKS_W   = 16;
  localparam int SIDX_W    = 4;
  localparam int BTN_IW    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CMP_W     = (BTN_IW > SIDX_W) ? BTN_IW : SIDX_W;
  localparam int THR_W     = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_CW    = 2'd2;
  localparam logic [1:0] KIND_CCW   = 2'd3;

  localparam logic [3:0] CTRL_OUTER = 4'd12;
  localparam logic [3:0] CTRL_INNER = 4'd13;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic REG_TICKS = 1'b0;
  localparam logic REG_SIDX  = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] ctrl;
    logic [7:0] mode;
    logic       shifted;
    logic [7:0] rep;
  } evt_t;

  typedef struct packed {
    logic push;
    logic flush;
    evt_t evt;
  } q_ctl_t;

  typedef struct packed {
    logic can_push;
    logic flush_done;
  } q_st_t;

  typedef struct packed {
    logic                   held;
    logic                   long_done;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   emit;
    logic [1:0]             kind;
    logic                   toggle;
  } btn_res_t;

  function automatic evt_t knob_evt(input logic [7:0] raw, input logic [3:0] ctrl,
                                    input logic [7:0] mode, input logic shifted);
    evt_t e;
    e.ctrl    = ctrl;
    e.mode    = mode;
    e.shifted = shifted;
    if (raw[7]) begin
      e.kind = KIND_CCW;
      e.rep  = 8'(-raw);
    end else begin
      e.kind = KIND_CW;
      e.rep  = raw;
    end
    return e;
  endfunction

endpackage

[hdl/ppke_btn_unit.sv]
module ppke_btn_unit
  import ppke_pkg::*;
(
  input  logic                   action,
  input  logic                   now,
  input  logic                   held,
  input  logic                   long_done,
  input  logic [COUNT_WIDTH-1:0] cnt,
  input  logic [TICKS_W-1:0]     thr,
  input  logic                   is_shift,
  output btn_res_t               res
);

  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign cnt_inc = (&cnt) ? cnt : cnt + COUNT_WIDTH'(1);

  always_comb begin
    res.held      = held;
    res.long_done = long_done;
    res.cnt       = cnt;
    res.emit      = 1'b0;
    res.kind      = KIND_SHORT;
    res.toggle    = 1'b0;
    if (action == ACT_REPORT) begin
      if (now && !held) begin
        res.held      = 1'b1;
        res.long_done = 1'b0;
        res.cnt       = '0;
      end else if (!now && held) begin
        res.emit      = !long_done;
        res.held      = 1'b0;
        res.long_done = 1'b0;
      end
    end else if (held && !long_done) begin
      res.cnt = cnt_inc;
      if (THR_W'(cnt_inc) >= THR_W'(thr)) begin
        res.long_done = 1'b1;
        res.toggle    = is_shift;
        res.emit      = !is_shift;
        res.kind      = KIND_LONG;
      end
    end
  end

endmodule

[hdl/ppke_evt_queue.sv]
module ppke_evt_queue
  import ppke_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_ctl_t                 ctl,
  output q_st_t                  st,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  logic pend_valid_r, pend_valid_nxt;
  evt_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  evt_t out_r, out_nxt;
  logic last_r, last_nxt;
  logic out_free;

  assign out_free      = !out_valid_r || out_tready;
  assign st.can_push   = out_free || !pend_valid_r;
  assign st.flush_done = out_free || !pend_valid_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nxt        = out_r;
    last_nxt       = last_r;
    if (ctl.push && st.can_push) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        last_nxt      = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = ctl.evt;
    end else if (ctl.flush && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = pend_r;
      last_nxt       = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {3'b000, out_r.rep, out_r.shifted, out_r.mode, out_r.ctrl};

endmodule

[hdl/panel_press_and_knob_event_generator.sv]
// Channel   Ports                     Beat contents
// in        in_tvalid/tready/tdata    report or tick, tuser = action
// out       out_tvalid/tready/tdata   one event, tuser = kind, tlast = final event
// cfg       cfg_psel ... cfg_prdata   0x0 long_press_ticks, 0x4 shift_button_index
//
// One input beat is accepted, then passes the outer and inner knob states (reports
// only), then the shared step unit one button per cycle (NUM_BUTTONS) while the queue
// does not stall it, then a flush state.
// A stalled output register plus a full pending event stalls any knob or button push.
// Reset is synchronous; the state, mode, button counters and flags and queue valid bits clear.
module panel_press_and_knob_event_generator
  import ppke_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // buttons[11:0], outer_turn[19:12], inner_turn[27:20], mode_code[35:28]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // control[3:0], mode[11:4], shifted[12], repeat_res[20:13]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // event_kind[1:0]
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OUTER = 3'd1;
  localparam logic [2:0] S_INNER = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [BTN_IW-1:0]  idx_r, idx_nxt;
  logic               action_r;
  logic [BTN_FIELD-1:0] btn_r;
  logic [7:0]         outer_r, inner_r;
  logic [7:0]         mode_r, mode_nxt;
  logic               shift_r, shift_nxt;
  logic [TICKS_W-1:0] ticks_r;
  logic [SIDX_W-1:0]  sidx_r;

  logic [NUM_BUTTONS-1:0] held_r, long_done_r;
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_BUTTONS];

  logic                   accept, commit, cfg_wr;
  logic [BTN_FIELD+NUM_BUTTONS-1:0] btn_wide;
  logic [NUM_BUTTONS-1:0] btn_ext;
  logic [TICKS_W-1:0]     thr;
  logic                   is_shift;
  btn_res_t               ures;
  q_ctl_t                 qctl;
  q_st_t                  qst;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SIDX) ? {28'd0, sidx_r} : {16'd0, ticks_r};

  assign btn_wide = {NUM_BUTTONS'(0), btn_r};
  assign btn_ext  = btn_wide[NUM_BUTTONS-1:0];
  assign thr      = (ticks_r == '0) ? TICKS_W'(1) : ticks_r;
  assign is_shift = (CMP_W'(sidx_r) == CMP_W'(idx_r));

  ppke_btn_unit u_unit (
    .action    (action_r),
    .now       (btn_ext[idx_r]),
    .held      (held_r[idx_r]),
    .long_done (long_done_r[idx_r]),
    .cnt       (cnt_r[idx_r]),
    .thr       (thr),
    .is_shift  (is_shift),
    .res       (ures)
  );

  ppke_evt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (qctl),
    .st         (qst),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    mode_nxt       = mode_r;
    shift_nxt      = shift_r;
    commit         = 1'b0;
    qctl.push      = 1'b0;
    qctl.flush     = 1'b0;
    qctl.evt       = knob_evt(outer_r, CTRL_OUTER, mode_r, shift_r);
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          if (in_tuser == ACT_REPORT) begin
            state_nxt = S_OUTER;
            if (in_tdata[35:28] != mode_r) begin
              mode_nxt  = in_tdata[35:28];
              shift_nxt = 1'b0;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_OUTER: begin
        qctl.push = (outer_r != 8'd0);
        if (!qctl.push || qst.can_push) begin
          state_nxt = S_INNER;
        end
      end
      S_INNER: begin
        qctl.evt  = knob_evt(inner_r, CTRL_INNER, mode_r, shift_r);
        qctl.push = (inner_r != 8'd0);
        if (!qctl.push || qst.can_push) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        qctl.evt.kind    = ures.kind;
        qctl.evt.ctrl    = 4'(idx_r);
        qctl.evt.rep     = 8'd1;
        qctl.push        = ures.emit;
        if (!ures.emit || qst.can_push) begin
          commit = 1'b1;
          if (ures.toggle) begin
            shift_nxt = !shift_r;
          end
          if (idx_r == BTN_IW'(NUM_BUTTONS - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + BTN_IW'(1);
          end
        end
      end
      S_FLUSH: begin
        qctl.flush = 1'b1;
        if (qst.flush_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      mode_r      <= '0;
      shift_r     <= 1'b0;
      ticks_r     <= TICKS_W'(50);
      sidx_r      <= SIDX_W'(5);
      held_r      <= '0;
      long_done_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mode_r  <= mode_nxt;
      shift_r <= shift_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_TICKS) begin
          ticks_r <= cfg_pwdata[TICKS_W-1:0];
        end else begin
          sidx_r <= cfg_pwdata[SIDX_W-1:0];
        end
      end
      if (commit) begin
        held_r[idx_r]      <= ures.held;
        long_done_r[idx_r] <= ures.long_done;
        cnt_r[idx_r]       <= ures.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_tuser;
      btn_r    <= in_tdata[11:0];
      outer_r  <= in_tdata[19:12];
      inner_r  <= in_tdata[27:20];
    end
  end

endmodule

[hdl/ppke_checker.sv]
module ppke_checker
  import ppke_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser,
  input logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the item was worked through");

  a_press_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[20:13] == 8'd1 && out_tdata[3:0] < 4'd12)
    else $error("press event with bad repeat or control");

  a_knob: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[20:13] != 8'd0 && (out_tdata[3:0] == CTRL_OUTER || out_tdata[3:0] == CTRL_INNER))
    else $error("rotation event with bad repeat or control");

endmodule

bind panel_press_and_knob_event_generator ppke_checker u_ppke_checker (.*);
